/* rtl/ble_advert_intrusion_detector_assert.svh */
// assertion macros for the advertisement intrusion detector checker
// used by bid_chk only; expects i_clk and i_rst_n in scope
`ifndef BLE_ADVERT_INTRUSION_DETECTOR_ASSERT_SVH
`define BLE_ADVERT_INTRUSION_DETECTOR_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define BID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bid assertion failed");

// next-cycle implication, checked through reset too
`define BID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bid assertion failed");

`endif

/* rtl/bid_pkg.sv */
// shared types and constants of the advertisement intrusion detector
// no dependencies; imported by bid_front, bid_exec, the top and the testbench
`timescale 1ns / 1ps
`default_nettype none

package bid_pkg;

    // table sizes
    localparam int BASELINE_DEPTH = 64;
    localparam int SEEN_DEPTH     = 64;
    localparam int TAG_DEPTH      = 32;

    localparam int KNOWN_IW = (BASELINE_DEPTH > 1) ? $clog2(BASELINE_DEPTH) : 1;
    localparam int KNOWN_FW = $clog2(BASELINE_DEPTH + 1);
    localparam int SEEN_IW  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int SEEN_FW  = $clog2(SEEN_DEPTH + 1);
    localparam int TAG_IW   = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

    localparam int SCAN_A = (BASELINE_DEPTH > SEEN_DEPTH) ? BASELINE_DEPTH : SEEN_DEPTH;
    localparam int SCAN_N = (SCAN_A > TAG_DEPTH) ? SCAN_A : TAG_DEPTH;
    localparam int SCAN_W = $clog2(SCAN_N + 1);

    // item queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam int SPAM_CATS = 5;
    localparam logic [15:0] SPAM_STEP = 16'd256;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADV  = 2'd0,
        OP_TICK = 2'd1,
        OP_MOVE = 2'd2,
        OP_LOAD = 2'd3
    } t_op;

    // vendor codes
    localparam logic [2:0] VND_PENTOOL    = 3'd1;
    localparam logic [2:0] VND_SWIFTPAIR  = 3'd2;
    localparam logic [2:0] VND_FASTPAIR   = 3'd3;
    localparam logic [2:0] VND_PHONE_PAIR = 3'd4;
    localparam logic [2:0] VND_CONTINUITY = 3'd5;
    localparam logic [2:0] VND_FINDMY     = 3'd6;
    localparam logic [2:0] VND_TRACKER    = 3'd7;

    // spam categories
    localparam logic [2:0] CAT_WIN_PAIR   = 3'd0;
    localparam logic [2:0] CAT_QUICK_PAIR = 3'd1;
    localparam logic [2:0] CAT_NEARBY     = 3'd2;
    localparam logic [2:0] CAT_PHONE_PAIR = 3'd3;
    localparam logic [2:0] CAT_OTHER      = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_FOX_EN    = 3'd0;
    localparam logic [2:0] REG_FOX_TGT   = 3'd1;
    localparam logic [2:0] REG_SPAM_HI   = 3'd2;
    localparam logic [2:0] REG_SPAM_LO   = 3'd3;
    localparam logic [2:0] REG_HOLD      = 3'd4;
    localparam logic [2:0] REG_STALK_N   = 3'd5;

    // classified item travelling through the queue
    typedef struct packed {
        t_op         op;
        logic [47:0] addr;
        logic [7:0]  rssi;
        logic        hid;
        logic        flipper;
        logic        cat_ok;
        logic [2:0]  cat;
        logic        tag_kind;
    } t_item;

    // configuration as seen by the back part
    typedef struct packed {
        logic        fox_en;
        logic        fox_clr;
        logic [47:0] fox_target;
        logic [15:0] spam_hi;
        logic [15:0] spam_lo;
        logic [3:0]  hold;
        logic [15:0] stalk_n;
    } t_cfg;

    // one result beat
    typedef struct packed {
        logic        hid_alert;
        logic        flipper_alert;
        logic        spam_alert;
        logic [2:0]  spam_category;
        logic        stalker_alert;
        logic [15:0] stalker_count;
        logic        fox_seen;
        logic [7:0]  fox_rssi;
        logic [15:0] alerts_total;
    } t_res;

    // one tag table entry
    typedef struct packed {
        logic [47:0] addr;
        logic [15:0] persist;
        logic [31:0] last_ep;
        logic        reported;
    } t_tag;

endpackage

`default_nettype wire

/* rtl/bid_front.sv */
// front part: classifies each input beat and queues it for the back part
// depends on bid_pkg
`timescale 1ns / 1ps
`default_nettype none

module bid_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_op,
    input  wire  [47:0]        i_dev_addr,
    input  wire  [7:0]         i_sig_rssi,
    input  wire  [2:0]         i_vendor_class,
    input  wire                i_nearby_type,
    input  wire                i_hid_advertised,
    input  wire                i_random_static,
    output logic               o_item_valid,
    output bid_pkg::t_item     o_item,
    input  wire                i_pop
);
    import bid_pkg::*;

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_IW-1:0]  r_wptr, r_rptr;
    logic [QUEUE_CW-1:0]  r_cnt;
    t_item                n_item;
    logic                 push;

    // classification of the incoming beat
    always_comb begin
        n_item          = '0;
        n_item.op       = t_op'(i_op);
        n_item.addr     = i_dev_addr;
        n_item.rssi     = i_sig_rssi;
        n_item.hid      = i_hid_advertised;
        n_item.flipper  = (i_vendor_class == VND_PENTOOL);
        n_item.tag_kind = (i_vendor_class == VND_FINDMY) || (i_vendor_class == VND_TRACKER)
                          || i_random_static;
        case (i_vendor_class)
            VND_SWIFTPAIR: begin
                n_item.cat_ok = 1'b1;
                n_item.cat    = CAT_WIN_PAIR;
            end
            VND_FASTPAIR: begin
                n_item.cat_ok = 1'b1;
                n_item.cat    = CAT_QUICK_PAIR;
            end
            VND_PHONE_PAIR: begin
                n_item.cat_ok = 1'b1;
                n_item.cat    = CAT_PHONE_PAIR;
            end
            VND_CONTINUITY: begin
                n_item.cat_ok = 1'b1;
                n_item.cat    = i_nearby_type ? CAT_NEARBY : CAT_OTHER;
            end
            default: begin
                n_item.cat_ok = 1'b0;
                n_item.cat    = CAT_WIN_PAIR;
            end
        endcase
    end

    assign o_stall      = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CW'(push) - QUEUE_CW'(i_pop);
        end
    end

endmodule

`default_nettype wire

/* rtl/bid_exec.sv */
// back part: table scans, spam levels, tag tracking and foxhunt state
// depends on bid_pkg; fed by bid_front
`timescale 1ns / 1ps
`default_nettype none

module bid_exec (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bid_pkg::t_cfg      i_cfg,
    input  wire                i_item_valid,
    input  bid_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_res_valid,
    output bid_pkg::t_res      o_res,
    input  wire                i_res_ready
);
    import bid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_OUT
    } t_state;

    t_state               r_state;
    t_item                r_item;
    t_res                 r_res;

    // tables
    logic [47:0]          r_known_mem [BASELINE_DEPTH];
    logic [47:0]          r_hid_mem   [SEEN_DEPTH];
    logic [47:0]          r_flp_mem   [SEEN_DEPTH];
    t_tag                 r_tag_mem   [TAG_DEPTH];
    logic [47:0]          r_known_rd, r_hid_rd, r_flp_rd;
    t_tag                 r_tag_rd;
    logic [TAG_DEPTH-1:0] r_tag_valid;
    logic [KNOWN_FW-1:0]  r_known_fill;
    logic [SEEN_FW-1:0]   r_hid_fill, r_flp_fill;

    // scan progress
    logic [SCAN_W-1:0]    r_cnt, r_pidx;
    logic                 r_pv;
    logic                 r_known_hit, r_hid_hit, r_flp_hit;
    logic                 r_tfound, r_ffound;
    logic [TAG_IW-1:0]    r_tslot, r_fslot;
    t_tag                 r_tent;

    // other state
    logic [15:0]          r_spam_lvl [SPAM_CATS];
    logic [SPAM_CATS-1:0] r_spam_flag;
    logic [31:0]          r_episode;
    logic [3:0]           r_motion_left;
    logic [7:0]           r_fox_rssi;
    logic                 r_fox_seen;
    logic [15:0]          r_tally;

    // scan compare on the registered read data
    logic [TAG_IW-1:0]    pidx_t;
    logic                 k_hit, h_hit, f_hit, t_in, t_hit, t_free;

    always_comb begin
        pidx_t = r_pidx[TAG_IW-1:0];
        t_in   = r_pidx < SCAN_W'(TAG_DEPTH);
        k_hit  = (r_pidx < SCAN_W'(r_known_fill)) && (r_known_rd == r_item.addr);
        h_hit  = (r_pidx < SCAN_W'(r_hid_fill)) && (r_hid_rd == r_item.addr);
        f_hit  = (r_pidx < SCAN_W'(r_flp_fill)) && (r_flp_rd == r_item.addr);
        t_hit  = t_in && r_tag_valid[pidx_t] && (r_tag_rd.addr == r_item.addr);
        t_free = t_in && !r_tag_valid[pidx_t];
    end

    // decision for the item at the end of its scan
    logic                 is_adv, fox_hit;
    logic                 a_hid, a_flp, a_spam, a_stalk;
    logic                 hid_wr, flp_wr, known_wr, tag_wr;
    logic [16:0]          spam_sum;
    logic [15:0]          spam_new;
    logic                 tag_go, slot_ok;
    logic [TAG_IW-1:0]    slot;
    t_tag                 ent;
    logic [2:0]           n_alerts;
    logic [16:0]          tally_sum;
    logic [15:0]          n_tally;
    logic [15:0]          stalk_cnt;

    always_comb begin
        is_adv    = (r_item.op == OP_ADV);
        fox_hit   = is_adv && i_cfg.fox_en && (r_item.addr == i_cfg.fox_target);
        a_hid     = is_adv && r_item.hid && !r_hid_hit;
        a_flp     = is_adv && r_item.flipper && !r_flp_hit;
        hid_wr    = a_hid && (r_hid_fill < SEEN_FW'(SEEN_DEPTH));
        flp_wr    = a_flp && (r_flp_fill < SEEN_FW'(SEEN_DEPTH));
        known_wr  = (r_item.op == OP_LOAD) && (r_known_fill < KNOWN_FW'(BASELINE_DEPTH));
        spam_sum  = {1'b0, r_spam_lvl[r_item.cat]} + {1'b0, SPAM_STEP};
        spam_new  = spam_sum[16] ? 16'hFFFF : spam_sum[15:0];
        a_spam    = is_adv && r_item.cat_ok && !r_spam_flag[r_item.cat]
                    && (spam_new >= i_cfg.spam_hi);
        tag_go    = is_adv && r_item.tag_kind && !r_known_hit;
        slot_ok   = r_tfound || r_ffound;
        slot      = r_tfound ? r_tslot : r_fslot;
        if (r_tfound) begin
            ent = r_tent;
        end else begin
            ent      = '0;
            ent.addr = r_item.addr;
        end
        a_stalk = 1'b0;
        if ((r_motion_left != '0) && (r_episode > ent.last_ep)) begin
            ent.last_ep = r_episode;
            if (ent.persist != 16'hFFFF) begin
                ent.persist = ent.persist + 16'd1;
            end
            if (!ent.reported && (ent.persist >= i_cfg.stalk_n)) begin
                ent.reported = 1'b1;
                a_stalk      = tag_go && slot_ok;
            end
        end
        tag_wr    = tag_go && slot_ok;
        stalk_cnt = tag_wr ? ent.persist : 16'd0;
        n_alerts  = 3'(a_hid) + 3'(a_flp) + 3'(a_spam) + 3'(a_stalk);
        tally_sum = {1'b0, r_tally} + 17'(n_alerts);
        n_tally   = tally_sum[16] ? 16'hFFFF : tally_sum[15:0];
    end

    // table reads, one address a cycle during the scan
    always_ff @(posedge i_clk) begin
        r_known_rd <= r_known_mem[r_cnt[KNOWN_IW-1:0]];
        r_hid_rd   <= r_hid_mem[r_cnt[SEEN_IW-1:0]];
        r_flp_rd   <= r_flp_mem[r_cnt[SEEN_IW-1:0]];
        r_tag_rd   <= r_tag_mem[r_cnt[TAG_IW-1:0]];
    end

    // table writes at the decision cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            if (known_wr) begin
                r_known_mem[r_known_fill[KNOWN_IW-1:0]] <= r_item.addr;
            end
            if (hid_wr) begin
                r_hid_mem[r_hid_fill[SEEN_IW-1:0]] <= r_item.addr;
            end
            if (flp_wr) begin
                r_flp_mem[r_flp_fill[SEEN_IW-1:0]] <= r_item.addr;
            end
            if (tag_wr) begin
                r_tag_mem[slot] <= ent;
            end
        end
    end

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tag_valid   <= '0;
            r_known_fill  <= '0;
            r_hid_fill    <= '0;
            r_flp_fill    <= '0;
            r_spam_flag   <= '0;
            r_episode     <= '0;
            r_motion_left <= '0;
            r_fox_rssi    <= '0;
            r_fox_seen    <= 1'b0;
            r_tally       <= '0;
            r_pv          <= 1'b0;
            r_cnt         <= '0;
            for (int i = 0; i < SPAM_CATS; i++) begin
                r_spam_lvl[i] <= '0;
            end
        end else begin
            if (i_cfg.fox_clr) begin
                r_fox_seen <= 1'b0;
                r_fox_rssi <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item      <= i_item;
                        r_cnt       <= '0;
                        r_pv        <= 1'b0;
                        r_known_hit <= 1'b0;
                        r_hid_hit   <= 1'b0;
                        r_flp_hit   <= 1'b0;
                        r_tfound    <= 1'b0;
                        r_ffound    <= 1'b0;
                        r_state     <= (i_item.op == OP_ADV) ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, compare the one issued before
                    r_pidx <= r_cnt;
                    if (r_cnt != SCAN_W'(SCAN_N)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_pv  <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_known_hit <= r_known_hit || k_hit;
                        r_hid_hit   <= r_hid_hit || h_hit;
                        r_flp_hit   <= r_flp_hit || f_hit;
                        if (!r_tfound && t_hit) begin
                            r_tfound <= 1'b1;
                            r_tslot  <= pidx_t;
                            r_tent   <= r_tag_rd;
                        end
                        if (!r_ffound && t_free) begin
                            r_ffound <= 1'b1;
                            r_fslot  <= pidx_t;
                        end
                        if (r_cnt == SCAN_W'(SCAN_N)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // state updates for every kind of item
                    case (r_item.op)
                        OP_ADV: begin
                            if (fox_hit) begin
                                r_fox_seen <= 1'b1;
                                r_fox_rssi <= r_item.rssi;
                            end
                            if (hid_wr) begin
                                r_hid_fill <= r_hid_fill + 1'b1;
                            end
                            if (flp_wr) begin
                                r_flp_fill <= r_flp_fill + 1'b1;
                            end
                            if (r_item.cat_ok) begin
                                r_spam_lvl[r_item.cat] <= spam_new;
                            end
                            if (a_spam) begin
                                r_spam_flag[r_item.cat] <= 1'b1;
                            end
                            if (tag_wr) begin
                                r_tag_valid[slot] <= 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (r_motion_left != '0) begin
                                r_motion_left <= r_motion_left - 4'd1;
                            end
                            for (int i = 0; i < SPAM_CATS; i++) begin
                                r_spam_lvl[i] <= r_spam_lvl[i] - (r_spam_lvl[i] >> 2);
                                if ((r_spam_lvl[i] - (r_spam_lvl[i] >> 2)) < i_cfg.spam_lo) begin
                                    r_spam_flag[i] <= 1'b0;
                                end
                            end
                        end
                        OP_MOVE: begin
                            if (r_motion_left == '0) begin
                                r_episode <= r_episode + 32'd1;
                            end
                            r_motion_left <= i_cfg.hold;
                        end
                        OP_LOAD: begin
                            if (known_wr) begin
                                r_known_fill <= r_known_fill + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_tally             <= n_tally;
                    r_res.hid_alert     <= a_hid;
                    r_res.flipper_alert <= a_flp;
                    r_res.spam_alert    <= a_spam;
                    r_res.spam_category <= (is_adv && r_item.cat_ok) ? r_item.cat
                                                                     : CAT_WIN_PAIR;
                    r_res.stalker_alert <= a_stalk;
                    r_res.stalker_count <= stalk_cnt;
                    r_res.fox_seen      <= r_fox_seen || fox_hit;
                    r_res.fox_rssi      <= fox_hit ? r_item.rssi
                                         : (r_fox_seen ? r_fox_rssi : 8'd0);
                    r_res.alerts_total  <= n_tally;
                    r_state             <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/ble_advert_intrusion_detector.sv */
// An advertisement is scanned against the baseline, seen and tag tables, one entry a
// cycle, before its decision; a tick, motion or baseline item goes straight to the
// decision. One item is worked on at a time: a new item is taken only after the last
// one's result has been handed to the output register.
// Reset: synchronous, active low; clears queue, counts, flags, valid bits and
// configuration to defaults. Tables use fill counts and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ble_advert_intrusion_detector (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_op,
    input  wire  [47:0] i_dev_addr,
    input  wire  [7:0]  i_sig_rssi,
    input  wire  [2:0]  i_vendor_class,
    input  wire         i_nearby_type,
    input  wire         i_hid_advertised,
    input  wire         i_random_static,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_hid_alert,
    output logic        o_flipper_alert,
    output logic        o_spam_alert,
    output logic [2:0]  o_spam_category,
    output logic        o_stalker_alert,
    output logic [15:0] o_stalker_count,
    output logic        o_fox_seen_out,
    output logic [7:0]  o_fox_rssi_out,
    output logic [15:0] o_alerts_total,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [47:0] i_cfg_wdata
);
    import bid_pkg::*;

    t_cfg   r_cfg;
    t_cfg   cfg;
    t_item  item;
    logic   item_valid, pop;
    t_res   res;
    logic   res_valid, res_ready;
    t_res   r_out;
    logic   r_ovalid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg            <= '0;
            r_cfg.spam_hi    <= 16'd6400;
            r_cfg.spam_lo    <= 16'd2560;
            r_cfg.hold       <= 4'd3;
            r_cfg.stalk_n    <= 16'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FOX_EN:  r_cfg.fox_en     <= i_cfg_wdata[0];
                REG_FOX_TGT: r_cfg.fox_target <= i_cfg_wdata;
                REG_SPAM_HI: r_cfg.spam_hi    <= i_cfg_wdata[15:0];
                REG_SPAM_LO: r_cfg.spam_lo    <= i_cfg_wdata[15:0];
                REG_HOLD:    r_cfg.hold       <= i_cfg_wdata[3:0];
                REG_STALK_N: r_cfg.stalk_n    <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // fox clear pulse rides along with the stored registers
    always_comb begin
        cfg         = r_cfg;
        cfg.fox_clr = i_cfg_we && (i_cfg_addr == REG_FOX_EN);
    end

    bid_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_dev_addr       (i_dev_addr),
        .i_sig_rssi       (i_sig_rssi),
        .i_vendor_class   (i_vendor_class),
        .i_nearby_type    (i_nearby_type),
        .i_hid_advertised (i_hid_advertised),
        .i_random_static  (i_random_static),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_pop            (pop)
    );

    bid_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // output register, refilled when empty or when its beat is taken
    assign res_ready = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_hid_alert     = r_out.hid_alert;
    assign o_flipper_alert = r_out.flipper_alert;
    assign o_spam_alert    = r_out.spam_alert;
    assign o_spam_category = r_out.spam_category;
    assign o_stalker_alert = r_out.stalker_alert;
    assign o_stalker_count = r_out.stalker_count;
    assign o_fox_seen_out  = r_out.fox_seen;
    assign o_fox_rssi_out  = r_out.fox_rssi;
    assign o_alerts_total  = r_out.alerts_total;

endmodule

`default_nettype wire

/* rtl/bid_chk.sv */
// port-level checker for the advertisement intrusion detector, bound to the top
// depends on ble_advert_intrusion_detector_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ble_advert_intrusion_detector_assert.svh"

module bid_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire [2:0]  o_spam_category,
    input wire        o_stalker_alert,
    input wire [15:0] o_stalker_count,
    input wire        o_fox_seen_out,
    input wire [7:0]  o_fox_rssi_out,
    input wire [15:0] o_alerts_total
);

    // a held result beat keeps its tally
    `BID_ASSERT_NEXT(a_hold, i_rst_n && o_valid && i_stall, !i_rst_n || (o_valid && $stable(o_alerts_total)))
    // rssi reads zero until the target is seen
    `BID_ASSERT_NOW(a_fox, o_valid && !o_fox_seen_out, o_fox_rssi_out == 8'd0)
    // only five spam categories exist
    `BID_ASSERT_NOW(a_cat, o_valid, o_spam_category <= 3'd4)
    // a stalker alert comes from a tag with some persistence and bumps the tally
    `BID_ASSERT_NOW(a_stalk, o_valid && o_stalker_alert, (o_stalker_count != 16'd0) && (o_alerts_total != 16'd0))
    // reset empties the output register
    `BID_ASSERT_NEXT(a_rst, !i_rst_n, !o_valid)

endmodule

bind ble_advert_intrusion_detector bid_chk u_bid_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_spam_category (o_spam_category),
    .o_stalker_alert (o_stalker_alert),
    .o_stalker_count (o_stalker_count),
    .o_fox_seen_out  (o_fox_seen_out),
    .o_fox_rssi_out  (o_fox_rssi_out),
    .o_alerts_total  (o_alerts_total)
);

`default_nettype wire

/* dv/tb.sv */
// testbench of the advertisement intrusion detector: directed table, random beats, then a baseline overfill
// depends on rtl/bid_pkg.sv and rtl/ble_advert_intrusion_detector.sv
`timescale 1ns / 1ps

module tb;
    import bid_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int N_RANDOM     = 1400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = '0;
    logic [47:0] i_dev_addr = '0;
    logic [7:0]  i_sig_rssi = '0;
    logic [2:0]  i_vendor_class = '0;
    logic        i_nearby_type = 1'b0;
    logic        i_hid_advertised = 1'b0;
    logic        i_random_static = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_hid_alert, o_flipper_alert, o_spam_alert, o_stalker_alert;
    logic [2:0]  o_spam_category;
    logic [15:0] o_stalker_count, o_alerts_total;
    logic        o_fox_seen_out;
    logic [7:0]  o_fox_rssi_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [47:0] i_cfg_wdata = '0;

    ble_advert_intrusion_detector u_top (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        t_op         op;
        logic [47:0] addr;
        logic [7:0]  rssi;
        logic [2:0]  vendor;
        logic        nearby;
        logic        hid;
        logic        rstatic;
    } t_adv_beat;

    // predictor state
    logic        fox_en;
    logic [47:0] fox_tgt;
    logic [15:0] spam_hi, spam_lo, stalk_n;
    logic [3:0]  hold;
    logic [47:0] known_tab [BASELINE_DEPTH];
    int          known_cnt;
    logic [47:0] hid_tab [SEEN_DEPTH];
    int          hid_cnt;
    logic [47:0] flp_tab [SEEN_DEPTH];
    int          flp_cnt;
    logic [15:0] spam_lvl [SPAM_CATS];
    logic        spam_on [SPAM_CATS];
    logic [47:0] tag_addr [TAG_DEPTH];
    logic [15:0] tag_cnt [TAG_DEPTH];
    logic [31:0] tag_ep [TAG_DEPTH];
    logic        tag_used [TAG_DEPTH];
    logic        tag_rep [TAG_DEPTH];
    logic [31:0] episode;
    logic [3:0]  move_left;
    logic [7:0]  fox_rssi;
    logic        fox_seen;
    logic [15:0] tally;

    t_res        expected_q [$];
    int          n_err = 0;
    bit          timed_out = 0;
    int          cycle = 0;
    bit          idle_off = 0;

    function automatic void reset_model();
        fox_en = 0; fox_tgt = '0; spam_hi = 16'd6400; spam_lo = 16'd2560;
        hold = 4'd3; stalk_n = 16'd3;
        known_cnt = 0; hid_cnt = 0; flp_cnt = 0;
        for (int i = 0; i < SPAM_CATS; i++) begin
            spam_lvl[i] = '0; spam_on[i] = 0;
        end
        for (int i = 0; i < TAG_DEPTH; i++) begin
            tag_addr[i] = '0; tag_cnt[i] = '0; tag_ep[i] = '0;
            tag_used[i] = 0; tag_rep[i] = 0;
        end
        episode = '0; move_left = '0; fox_rssi = '0; fox_seen = 0; tally = '0;
    endfunction

    function automatic void bump_tally();
        if (tally != 16'hFFFF) tally++;
    endfunction

    function automatic bit in_known(logic [47:0] a);
        for (int i = 0; i < known_cnt; i++) if (known_tab[i] == a) return 1;
        return 0;
    endfunction

    function automatic bit hid_first(logic [47:0] a);
        for (int i = 0; i < hid_cnt; i++) if (hid_tab[i] == a) return 0;
        if (hid_cnt < SEEN_DEPTH) hid_tab[hid_cnt++] = a;
        bump_tally();
        return 1;
    endfunction

    function automatic bit flipper_first(logic [47:0] a);
        for (int i = 0; i < flp_cnt; i++) if (flp_tab[i] == a) return 0;
        if (flp_cnt < SEEN_DEPTH) flp_tab[flp_cnt++] = a;
        bump_tally();
        return 1;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [47:0] v);
        case (idx)
            REG_FOX_EN: begin
                fox_en = v[0]; fox_seen = 0; fox_rssi = '0;
            end
            REG_FOX_TGT: fox_tgt = v;
            REG_SPAM_HI: spam_hi = v[15:0];
            REG_SPAM_LO: spam_lo = v[15:0];
            REG_HOLD:    hold = v[3:0];
            REG_STALK_N: stalk_n = v[15:0];
            default: ;
        endcase
    endfunction

    // works out the alert beat caused by one item
    function automatic t_res detect(t_adv_beat b);
        t_res r;
        int   cat, slot, free_slot;
        logic [16:0] lv;
        r = '0;
        case (b.op)
            OP_ADV: begin
                cat = -1;
                if (fox_en && b.addr == fox_tgt) begin
                    fox_rssi = b.rssi; fox_seen = 1;
                end
                if (b.hid) r.hid_alert = hid_first(b.addr);
                if (b.vendor == VND_PENTOOL) r.flipper_alert = flipper_first(b.addr);
                case (b.vendor)
                    VND_SWIFTPAIR:  cat = CAT_WIN_PAIR;
                    VND_FASTPAIR:   cat = CAT_QUICK_PAIR;
                    VND_PHONE_PAIR: cat = CAT_PHONE_PAIR;
                    VND_CONTINUITY: cat = b.nearby ? CAT_NEARBY : CAT_OTHER;
                    default: ;
                endcase
                if (cat >= 0) begin
                    lv = {1'b0, spam_lvl[cat]} + 17'd256;
                    spam_lvl[cat] = lv[16] ? 16'hFFFF : lv[15:0];
                    r.spam_category = cat[2:0];
                    if (!spam_on[cat] && spam_lvl[cat] >= spam_hi) begin
                        spam_on[cat] = 1; r.spam_alert = 1; bump_tally();
                    end
                end
                if ((b.vendor == VND_FINDMY || b.vendor == VND_TRACKER || b.rstatic)
                        && !in_known(b.addr)) begin
                    slot = -1; free_slot = -1;
                    for (int i = 0; i < TAG_DEPTH; i++) begin
                        if (tag_used[i] && tag_addr[i] == b.addr) begin
                            slot = i; break;
                        end
                        if (!tag_used[i] && free_slot < 0) free_slot = i;
                    end
                    if (slot < 0 && free_slot >= 0) begin
                        slot = free_slot; tag_used[slot] = 1; tag_addr[slot] = b.addr;
                        tag_cnt[slot] = '0; tag_ep[slot] = '0; tag_rep[slot] = 0;
                    end
                    if (slot >= 0) begin
                        if (move_left > 0 && episode > tag_ep[slot]) begin
                            tag_ep[slot] = episode;
                            if (tag_cnt[slot] != 16'hFFFF) tag_cnt[slot]++;
                            if (!tag_rep[slot] && tag_cnt[slot] >= stalk_n) begin
                                tag_rep[slot] = 1; r.stalker_alert = 1; bump_tally();
                            end
                        end
                        r.stalker_count = tag_cnt[slot];
                    end
                end
            end
            OP_TICK: begin
                if (move_left > 0) move_left--;
                for (int i = 0; i < SPAM_CATS; i++) begin
                    spam_lvl[i] = spam_lvl[i] - (spam_lvl[i] >> 2);
                    if (spam_on[i] && spam_lvl[i] < spam_lo) spam_on[i] = 0;
                end
            end
            OP_MOVE: begin
                if (move_left == 0) episode++;
                move_left = hold;
            end
            default: begin
                if (known_cnt < BASELINE_DEPTH) known_tab[known_cnt++] = b.addr;
            end
        endcase
        r.fox_seen = fox_seen;
        r.fox_rssi = fox_seen ? fox_rssi : 8'd0;
        r.alerts_total = tally;
        return r;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_hid_alert, o_flipper_alert, o_spam_alert, o_spam_category,
                    o_stalker_alert, o_stalker_count, o_fox_seen_out, o_fox_rssi_out,
                    o_alerts_total};
            if (expected_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= idle_off ? 1'b0 : ($urandom_range(99) < 14);
    end

    task automatic cfg_write(logic [2:0] idx, logic [47:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, v);
    endtask

    // wait for all results, then an idle gap
    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // send one item; fixed overrides the predictor when check_fixed is set
    task automatic send(t_adv_beat b, bit check_fixed = 0, t_res fixed = '0);
        t_res r;
        @(negedge i_clk);
        while (!idle_off && $urandom_range(99) < 14) @(negedge i_clk);
        i_valid <= 1'b1; i_op <= b.op; i_dev_addr <= b.addr; i_sig_rssi <= b.rssi;
        i_vendor_class <= b.vendor; i_nearby_type <= b.nearby;
        i_hid_advertised <= b.hid; i_random_static <= b.rstatic;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = detect(b);
        expected_q.push_back(check_fixed ? fixed : r);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // biased random item over a small address pool
    function automatic t_adv_beat rand_beat(int pool);
        t_adv_beat b;
        int k;
        k = $urandom_range(99);
        b.op = k < 70 ? OP_ADV : k < 85 ? OP_TICK : k < 95 ? OP_MOVE : OP_LOAD;
        b.addr = $urandom_range(15) < 2 ? 48'({$urandom, $urandom})
                                        : 48'hA0B0_0000_0000 + $urandom_range(pool - 1);
        b.rssi = 8'($urandom);
        b.vendor = 3'($urandom);
        b.nearby = 1'($urandom);
        b.hid = $urandom_range(3) == 0;
        b.rstatic = 1'($urandom);
        return b;
    endfunction

    t_adv_beat dir_tab [$];

    initial begin
        t_adv_beat b;
        reset_model();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: extremes, every op and vendor, special cases
        dir_tab.push_back('{OP_TICK, 48'h0, 8'h00, 3'd0, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'hFFFF_FFFF_FFFF, 8'h80, VND_PENTOOL, 1, 1, 1});
        dir_tab.push_back('{OP_ADV, 48'hFFFF_FFFF_FFFF, 8'h7F, VND_PENTOOL, 1, 1, 1});
        dir_tab.push_back('{OP_MOVE, 48'h0, 8'h00, 3'd0, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h1234_5678_9ABC, 8'hC0, VND_FINDMY, 0, 0, 0});
        dir_tab.push_back('{OP_LOAD, 48'h0000_0000_0007, 8'h00, 3'd0, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h0000_0000_0007, 8'h10, VND_TRACKER, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h2, 8'h10, VND_SWIFTPAIR, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h3, 8'h10, VND_FASTPAIR, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h4, 8'h10, VND_PHONE_PAIR, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h5, 8'h10, VND_CONTINUITY, 1, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h5, 8'h10, VND_CONTINUITY, 0, 0, 0});
        dir_tab.push_back('{OP_ADV, 48'h0, 8'h10, 3'd0, 0, 1, 1});
        dir_tab.push_back('{OP_MOVE, 48'h0, 8'h00, 3'd0, 0, 0, 0});
        dir_tab.push_back('{OP_TICK, 48'h0, 8'h00, 3'd0, 0, 0, 0});
        for (int i = 0; i < dir_tab.size(); i++) begin
            // first row right after reset: everything quiet
            if (i == 0) send(dir_tab[i], 1, '0);
            else send(dir_tab[i]);
        end
        drain();

        // register sweep with extremes; fox target and stalker threshold of one
        cfg_write(REG_FOX_EN, 48'h1);
        cfg_write(REG_FOX_TGT, 48'hA0B0_0000_0003);
        cfg_write(REG_SPAM_HI, 48'd512);
        cfg_write(REG_SPAM_LO, 48'hFFFF);
        cfg_write(REG_HOLD, 48'd0);
        cfg_write(REG_STALK_N, 48'd1);
        cfg_write(3'd7, 48'hFFFF_FFFF_FFFF);
        cfg_write(3'd6, 48'h0);

        // random phases with different settings
        for (int ph = 0; ph < 4; ph++) begin
            idle_off = (ph == 2);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                b = rand_beat(ph == 3 ? 200 : 24);
                if (ph == 0 && n % 7 == 0) b.addr = fox_tgt;
                send(b);
            end
            drain();
            case (ph)
                0: begin
                    cfg_write(REG_SPAM_HI, 48'hFFFF);
                    cfg_write(REG_SPAM_LO, 48'd0);
                    cfg_write(REG_HOLD, 48'hF);
                    cfg_write(REG_STALK_N, 48'hFFFF);
                end
                1: begin
                    cfg_write(REG_FOX_EN, 48'h0);
                    cfg_write(REG_SPAM_HI, 48'd0);
                    cfg_write(REG_SPAM_LO, 48'd2560);
                    cfg_write(REG_HOLD, 48'd3);
                    cfg_write(REG_STALK_N, 48'd2);
                end
                2: begin
                    cfg_write(REG_FOX_EN, 48'h1);
                    cfg_write(REG_FOX_TGT, 48'hFFFF_FFFF_FFFF);
                    cfg_write(REG_SPAM_HI, 48'd6400);
                end
                default: ;
            endcase
        end
        idle_off = 0;

        // fill the baseline past its end
        for (int n = 0; n < 70; n++) begin
            b = '{OP_LOAD, 48'hB000_0000_0000 + n, 8'h00, 3'd0, 0, 0, 0};
            send(b);
        end
        drain();

        if (n_err == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/bid_pkg.sv
rtl/bid_front.sv
rtl/bid_exec.sv
rtl/ble_advert_intrusion_detector.sv
rtl/bid_chk.sv
dv/tb.sv
